@@ hw/rtl/tpps_pkg.sv @@
package tpps_pkg;

   // Task table size. Ids are 4 bits wide on both channels.
   localparam int TASK_COUNT = 16;
   localparam int PID_W      = $clog2(TASK_COUNT);

   typedef logic [PID_W-1:0] pid_type;
   typedef logic [2:0]       opcode_type;
   typedef logic [1:0]       tstate_type;
   typedef logic [2:0]       status_type;

   localparam opcode_type OP_CREATE   = 3'd0;
   localparam opcode_type OP_KILL     = 3'd1;
   localparam opcode_type OP_SCHEDULE = 3'd2;
   localparam opcode_type OP_BLOCK    = 3'd3;
   localparam opcode_type OP_UNBLOCK  = 3'd4;

   localparam tstate_type ST_READY   = 2'd0;
   localparam tstate_type ST_BLOCKED = 2'd1;
   localparam tstate_type ST_SUSPEND = 2'd2;
   localparam tstate_type ST_CURRENT = 2'd3;

   localparam status_type STATUS_OK         = 3'd0;
   localparam status_type STATUS_NO_FREE    = 3'd1;
   localparam status_type STATUS_IS_CURRENT = 3'd2;
   localparam status_type STATUS_NOT_FOUND  = 3'd3;
   localparam status_type STATUS_BAD_STATE  = 3'd4;

   typedef struct packed {
      opcode_type opcode;
      pid_type    target_pid;
      logic       new_priority;
      tstate_type park_state;
   } req_type;

   typedef struct packed {
      status_type status;
      pid_type    result_pid;
   } rsp_type;

   // One task joins the tail of some queue.
   typedef struct packed {
      logic    en;
      pid_type id;
   } append_type;

   // Oldest member of each ready queue.
   typedef struct packed {
      logic    sys_valid;
      pid_type sys_pid;
      logic    usr_valid;
      pid_type usr_pid;
   } heads_type;

endpackage

@@ hw/rtl/tpps_req_if.sv @@
interface tpps_req_if;
   import tpps_pkg::*;

   logic       valid;
   logic       ready;
   opcode_type opcode;
   pid_type    target_pid;
   logic       new_priority;
   tstate_type park_state;

   modport source (output valid, output opcode, output target_pid,
                   output new_priority, output park_state, input ready);
   modport sink   (input valid, input opcode, input target_pid,
                   input new_priority, input park_state, output ready);
endinterface

@@ hw/rtl/tpps_rsp_if.sv @@
interface tpps_rsp_if;
   import tpps_pkg::*;

   logic       valid;
   logic       ready;
   status_type status;
   pid_type    result_pid;

   modport source (output valid, output status, output result_pid, input ready);
   modport sink   (input valid, input status, input result_pid, output ready);
endinterface

@@ hw/rtl/tpps_age_matrix.sv @@
module tpps_age_matrix (
   input  logic                          clock,
   input  tpps_pkg::append_type          append,
   input  logic [tpps_pkg::TASK_COUNT-1:0] sys_mask,
   input  logic [tpps_pkg::TASK_COUNT-1:0] usr_mask,
   output tpps_pkg::heads_type           heads
);
   import tpps_pkg::*;

   // older_ff[r][c] set: task c joined its queue before task r.
   logic [TASK_COUNT-1:0][TASK_COUNT-1:0] older_ff;
   logic [TASK_COUNT-1:0][TASK_COUNT-1:0] older_in;
   logic [TASK_COUNT-1:0]                 sys_oldest;
   logic [TASK_COUNT-1:0]                 usr_oldest;

   // A newcomer is younger than everyone else.
   always_comb begin
      older_in = older_ff;
      if (append.en) begin
         for (int r = 0; r < TASK_COUNT; r++) begin
            older_in[r][append.id] = 1'b0;
         end
         for (int c = 0; c < TASK_COUNT; c++) begin
            older_in[append.id][c] = (PID_W'(c) != append.id);
         end
      end
   end

   always_ff @(posedge clock) begin
      older_ff <= older_in;
   end

   // A member is the head when no other member of its queue is older.
   always_comb begin
      heads = '0;
      for (int i = 0; i < TASK_COUNT; i++) begin
         sys_oldest[i] = sys_mask[i] & ~(|(sys_mask & older_ff[i]));
         usr_oldest[i] = usr_mask[i] & ~(|(usr_mask & older_ff[i]));
      end
      for (int i = 0; i < TASK_COUNT; i++) begin
         heads.sys_pid = heads.sys_pid | (sys_oldest[i] ? PID_W'(i) : '0);
         heads.usr_pid = heads.usr_pid | (usr_oldest[i] ? PID_W'(i) : '0);
      end
      heads.sys_valid = |sys_mask;
      heads.usr_valid = |usr_mask;
   end

endmodule

@@ hw/rtl/tpps_sched.sv @@
module tpps_sched (
   input  logic              clock,
   input  logic              reset,
   input  logic              cmd_valid,
   input  tpps_pkg::req_type cmd,
   output tpps_pkg::rsp_type rsp
);
   import tpps_pkg::*;

   logic [TASK_COUNT-1:0]             in_use_ff, in_use_in;
   logic [TASK_COUNT-1:0]             prio_ff, prio_in;
   tstate_type [TASK_COUNT-1:0]       state_ff, state_in;
   pid_type                           cur_ff, cur_in;
   logic                              cur_prio_ff, cur_prio_in;

   logic [TASK_COUNT-1:0] queued;
   logic [TASK_COUNT-1:0] sys_mask;
   logic [TASK_COUNT-1:0] usr_mask;
   pid_type               free_pid;
   logic                  free_found;
   append_type            append;
   append_type            age_append;
   heads_type             heads;
   logic                  tgt_queued;
   tstate_type            tgt_state;
   logic                  do_park;
   tstate_type            park_st;
   logic                  cur_joins_sys;
   logic                  cur_joins_usr;
   pid_type               next_pid;
   logic                  next_prio;

   // Idle task and the running task never sit in a queue.
   always_comb begin
      for (int i = 0; i < TASK_COUNT; i++) begin
         queued[i]   = in_use_ff[i] && (i != 0) && (PID_W'(i) != cur_ff);
         sys_mask[i] = queued[i] && (state_ff[i] == ST_READY) && !prio_ff[i];
         usr_mask[i] = queued[i] && (state_ff[i] == ST_READY) && prio_ff[i];
      end
   end

   // Lowest free id.
   always_comb begin
      free_pid = '0;
      for (int i = TASK_COUNT - 1; i >= 0; i--) begin
         if (!in_use_ff[i]) begin
            free_pid = PID_W'(i);
         end
      end
      free_found = ~(&in_use_ff);
   end

   assign tgt_queued = queued[cmd.target_pid];
   assign tgt_state  = state_ff[cmd.target_pid];

   // Only an executed command reorders the queues.
   assign age_append.en = cmd_valid && append.en;
   assign age_append.id = append.id;

   tpps_age_matrix u_age (
      .clock    (clock),
      .append   (age_append),
      .sys_mask (sys_mask),
      .usr_mask (usr_mask),
      .heads    (heads)
   );

   always_comb begin
      in_use_in     = in_use_ff;
      prio_in       = prio_ff;
      state_in      = state_ff;
      cur_in        = cur_ff;
      cur_prio_in   = cur_prio_ff;
      append        = '0;
      rsp.status    = STATUS_OK;
      rsp.result_pid = cur_ff;
      do_park       = 1'b0;
      park_st       = ST_READY;
      cur_joins_sys = 1'b0;
      cur_joins_usr = 1'b0;
      next_pid      = '0;
      next_prio     = 1'b0;

      case (cmd.opcode)
         OP_CREATE: begin
            if (free_found) begin
               in_use_in[free_pid] = 1'b1;
               state_in[free_pid]  = ST_READY;
               prio_in[free_pid]   = cmd.new_priority;
               append.en           = 1'b1;
               append.id           = free_pid;
               rsp.result_pid      = free_pid;
            end else begin
               rsp.status     = STATUS_NO_FREE;
               rsp.result_pid = '0;
            end
         end
         OP_KILL: begin
            rsp.result_pid = cmd.target_pid;
            if (cmd.target_pid == cur_ff) begin
               rsp.status = STATUS_IS_CURRENT;
            end else if (!tgt_queued) begin
               rsp.status = STATUS_NOT_FOUND;
            end else begin
               in_use_in[cmd.target_pid] = 1'b0;
               state_in[cmd.target_pid]  = ST_READY;
               prio_in[cmd.target_pid]   = 1'b0;
            end
         end
         OP_SCHEDULE: begin
            if (cmd.park_state == ST_CURRENT) begin
               rsp.status = STATUS_BAD_STATE;
            end else begin
               do_park = 1'b1;
               park_st = cmd.park_state;
            end
         end
         OP_BLOCK: begin
            if (cmd.target_pid == cur_ff) begin
               do_park = 1'b1;
               park_st = ST_BLOCKED;
            end else if (!tgt_queued) begin
               rsp.status = STATUS_NOT_FOUND;
            end else if (tgt_state != ST_READY) begin
               rsp.status = STATUS_BAD_STATE;
            end else begin
               state_in[cmd.target_pid] = ST_SUSPEND;
               append.en                = 1'b1;
               append.id                = cmd.target_pid;
            end
         end
         OP_UNBLOCK: begin
            rsp.result_pid = cmd.target_pid;
            if (cmd.target_pid == cur_ff) begin
               rsp.status = STATUS_IS_CURRENT;
            end else if (!tgt_queued) begin
               rsp.status = STATUS_NOT_FOUND;
            end else if (tgt_state != ST_BLOCKED) begin
               rsp.status = STATUS_BAD_STATE;
            end else begin
               state_in[cmd.target_pid] = ST_READY;
               append.en                = 1'b1;
               append.id                = cmd.target_pid;
            end
         end
         default: begin
            rsp.status = STATUS_BAD_STATE;
         end
      endcase

      // Park the running task at its queue tail, then pick the next one.
      // A parked ready task is the youngest, so it only wins on an empty queue.
      if (do_park) begin
         state_in[cur_ff] = park_st;
         if (cur_ff != '0) begin
            append.en = 1'b1;
            append.id = cur_ff;
         end
         cur_joins_sys = (cur_ff != '0) && (park_st == ST_READY) && !cur_prio_ff;
         cur_joins_usr = (cur_ff != '0) && (park_st == ST_READY) && cur_prio_ff;
         if (heads.sys_valid) begin
            next_pid  = heads.sys_pid;
            next_prio = 1'b0;
         end else if (cur_joins_sys) begin
            next_pid  = cur_ff;
            next_prio = 1'b0;
         end else if (heads.usr_valid) begin
            next_pid  = heads.usr_pid;
            next_prio = 1'b1;
         end else if (cur_joins_usr) begin
            next_pid  = cur_ff;
            next_prio = 1'b1;
         end
         state_in[next_pid] = ST_CURRENT;
         cur_in             = next_pid;
         cur_prio_in        = next_prio;
         rsp.result_pid     = next_pid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_use_ff    <= TASK_COUNT'(1);
         prio_ff      <= '0;
         // Idle task runs; every other entry is ready.
         state_ff     <= (2*TASK_COUNT)'(ST_CURRENT);
         cur_ff       <= '0;
         cur_prio_ff  <= 1'b0;
      end else if (cmd_valid) begin
         in_use_ff    <= in_use_in;
         prio_ff      <= prio_in;
         state_ff     <= state_in;
         cur_ff       <= cur_in;
         cur_prio_ff  <= cur_prio_in;
      end
   end

   a_idle_in_use: assert property (@(posedge clock) disable iff (reset)
      in_use_ff[0])
      else $error("idle task id released");

   a_current_in_use: assert property (@(posedge clock) disable iff (reset)
      in_use_ff[cur_ff])
      else $error("running task id is free");

   a_current_state: assert property (@(posedge clock) disable iff (reset)
      (cur_ff != '0) |-> (state_ff[cur_ff] == ST_CURRENT))
      else $error("running task not marked current");

endmodule

@@ hw/rtl/two_priority_process_scheduler_core.sv @@
// Two-level priority task scheduler. Task id 0 is the idle task and runs
// after reset. Each request transaction carries one command (create, kill,
// schedule, block, unblock) and yields exactly one response transaction with a
// status and a task id. Ready tasks are served first-in first-out, system
// priority ahead of user priority; the idle task runs when both ready queues
// are empty. A command is captured in an input register, executed in a single
// pass against the task table and queue order matrix once the output register
// is free or draining, and its response is held in that output register. One
// command can be accepted every cycle while responses are taken, set by the
// single update of the task table per cycle. Backpressure on the response side
// propagates to req_if.ready within the same cycle.
module two_priority_process_scheduler_core (
   input logic        clock,
   input logic        reset,
   tpps_req_if.sink   req_if,
   tpps_rsp_if.source rsp_if
);
   import tpps_pkg::*;

   logic    in_valid_ff, in_valid_in;
   req_type in_cmd_ff;
   logic    out_valid_ff, out_valid_in;
   rsp_type out_rsp_ff;
   rsp_type exec_rsp;
   logic    advance;
   logic    req_accept;

   // Execute the held command when the output slot is free or draining.
   assign advance      = in_valid_ff && (!out_valid_ff || rsp_if.ready);
   assign req_if.ready = !in_valid_ff || advance;
   assign req_accept   = req_if.valid && req_if.ready;

   assign in_valid_in  = req_accept || (in_valid_ff && !advance);
   assign out_valid_in = advance || (out_valid_ff && !rsp_if.ready);

   // Capture the request transaction.
   always_ff @(posedge clock) begin
      if (req_accept) begin
         in_cmd_ff.opcode       <= req_if.opcode;
         in_cmd_ff.target_pid   <= req_if.target_pid;
         in_cmd_ff.new_priority <= req_if.new_priority;
         in_cmd_ff.park_state   <= req_if.park_state;
      end
   end

   // Task table, queue order and command execution.
   tpps_sched u_sched (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (advance),
      .cmd       (in_cmd_ff),
      .rsp       (exec_rsp)
   );

   // Hold the response until the sink takes it.
   always_ff @(posedge clock) begin
      if (advance) begin
         out_rsp_ff <= exec_rsp;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   assign rsp_if.valid      = out_valid_ff;
   assign rsp_if.status     = out_rsp_ff.status;
   assign rsp_if.result_pid = out_rsp_ff.result_pid;

   a_exec_fills_output: assert property (@(posedge clock) disable iff (reset)
      advance |=> out_valid_ff)
      else $error("executed command produced no response");

   a_output_from_exec: assert property (@(posedge clock) disable iff (reset)
      $rose(out_valid_ff) |-> $past(advance))
      else $error("response appeared without an executed command");

   a_stalled_cmd_kept: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && !advance) |=> (in_valid_ff && $stable(in_cmd_ff)))
      else $error("stalled command lost or overwritten");

endmodule
